### sv/magnetometer_heading_filter_macros.svh
// ----------------------------------------------------------------------------
// Magnetometer heading filter assertion macros
// Shared concurrent assertion forms used by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_HEADING_FILTER_MACROS_SVH
`define MAGNETOMETER_HEADING_FILTER_MACROS_SVH

// Same-cycle implication
`define MHF_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication
`define MHF_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

### sv/mhf_pkg.sv
// ----------------------------------------------------------------------------
// Magnetometer heading filter package
// Beat types, register codes, CORDIC angle table and sector lookup.
// ----------------------------------------------------------------------------
package mhf_pkg;

  localparam int WINDOW_DEPTH_DEF = 5;

  // Shared serial multiplier widths
  localparam int MUL_AW = 25;
  localparam int MUL_BW = 24;
  localparam int MUL_PW = 49;

  localparam logic [MUL_BW-1:0] ALPHA_Q16 = 24'd6554;

  // Angle units: 2^-15 degree fine, 1/128 degree coarse
  localparam int FULL_TURN    = 46080;
  localparam int SECTOR_SPAN  = 5760;
  localparam int HALF_SECTOR  = 2880;
  localparam int CORDIC_STEPS = 22;
  localparam int DEG_UNIT     = 32768;

  localparam logic [20:0] ATAN_TABLE [CORDIC_STEPS] = '{
    21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189, 21'd58652,
    21'd29333, 21'd14667, 21'd7334, 21'd3667, 21'd1833, 21'd917, 21'd458,
    21'd229, 21'd115, 21'd57, 21'd29, 21'd14, 21'd7, 21'd4, 21'd2, 21'd1
  };

  localparam logic [3:0] SECTOR_CODES [8] = '{
    4'd6, 4'd1, 4'd5, 4'd2, 4'd7, 4'd3, 4'd8, 4'd4
  };

  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_OFFSET_X     = 3'd0,
    CFG_OFFSET_Y     = 3'd1,
    CFG_OFFSET_Z     = 3'd2,
    CFG_JUMP_LIMIT   = 3'd3,
    CFG_HEADING_TRIM = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] smooth_x;
    logic signed [23:0] smooth_y;
    logic signed [23:0] smooth_z;
    logic [23:0]        field_strength;
    logic [15:0]        heading;
    logic [15:0]        trimmed_heading;
    logic [3:0]         compass_sector;
  } out_item_t;

  // Handshake status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

  // 45-degree sector code of a heading in 1/128 degree
  function automatic logic [3:0] sector_of(input logic [15:0] h);
    logic [16:0] v;
    logic [3:0]  q;
    v = {1'b0, h} + 17'(HALF_SECTOR);
    q = '0;
    for (int k = 1; k <= 8; k++) begin
      if (v >= 17'(k * SECTOR_SPAN)) q = q + 4'd1;
    end
    return SECTOR_CODES[q[2:0]];
  endfunction

endpackage

### sv/mhf_mul.sv
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module mhf_mul import mhf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0]        b,
  output unit_st_t                 st,
  output logic signed [MUL_PW-1:0] product
);

  logic signed [MUL_PW-1:0] acc;
  logic signed [MUL_PW-1:0] areg;
  logic [MUL_BW-1:0]        breg;
  logic signed [MUL_PW-1:0] acc_next;
  logic                     last_bit;

  // Add the shifted multiplicand when the low multiplier bit is set
  always_comb begin
    acc_next = breg[0] ? acc + areg : acc;
    // stop once no multiplier bits remain
    last_bit = st.busy && !start && (breg[MUL_BW-1:1] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st.done <= last_bit;
      if (start) begin
        acc     <= '0;
        areg    <= {{(MUL_PW-MUL_AW){a[MUL_AW-1]}}, a};
        breg    <= b;
        st.busy <= 1'b1;
      end else if (st.busy) begin
        acc  <= acc_next;
        areg <= areg <<< 1;
        breg <= breg >> 1;
        if (last_bit) begin
          st.busy <= 1'b0;
          product <= acc_next;
        end
      end
    end
  end

endmodule

### sv/mhf_cordic.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC heading unit
// atan2(y,x) + 90 degrees in 1/128 degree, one rotation step a cycle.
// ----------------------------------------------------------------------------
module mhf_cordic import mhf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [23:0] fx,
  input  logic signed [23:0] fy,
  output unit_st_t           st,
  output logic [15:0]        heading
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  localparam logic signed [25:0] TURN_FINE    = 26'sd11796480;
  localparam logic signed [25:0] QUARTER_FINE = 26'sd2949120;
  localparam logic signed [25:0] HALF_FINE    = 26'sd5898240;

  cstate_t            state;
  logic [4:0]         iter;
  logic signed [35:0] x, y;
  logic signed [25:0] z;

  logic signed [35:0] xs, ys, x_ld, y_ld;
  logic signed [25:0] atan_v, a0, a1, a2, hr;
  logic               ypos;
  logic [15:0]        h_fin;

  always_comb begin
    // load: scale by 256, fold the left half plane
    x_ld   = {{4{fx[23]}}, fx, 8'd0};
    y_ld   = {{4{fy[23]}}, fy, 8'd0};
    // one micro-rotation
    xs     = x >>> iter;
    ys     = y >>> iter;
    ypos   = !y[35] && (y != '0);
    atan_v = {5'd0, ATAN_TABLE[iter]};
    // offset, wrap into one turn, round to 1/128 degree
    a0 = z + QUARTER_FINE;
    a1 = a0[25] ? a0 + TURN_FINE : a0;
    a2 = (a1 >= TURN_FINE) ? a1 - TURN_FINE : a1;
    hr = (a2 + 26'sd128) >>> 8;
    h_fin = (hr >= 26'(FULL_TURN)) ? 16'd0 : hr[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      st    <= '0;
    end else begin
      st.done <= (state == C_FIN);
      case (state)
        C_IDLE: begin
          if (start) begin
            st.busy <= 1'b1;
            iter    <= '0;
            if (fx == '0 && fy == '0) begin
              z     <= '0;
              state <= C_FIN;
            end else if (fx[23]) begin
              x     <= -x_ld;
              y     <= -y_ld;
              z     <= HALF_FINE;
              state <= C_RUN;
            end else begin
              x     <= x_ld;
              y     <= y_ld;
              z     <= '0;
              state <= C_RUN;
            end
          end
        end
        C_RUN: begin
          if (ypos) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_v;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_v;
          end
          iter <= iter + 5'd1;
          if (iter == 5'(CORDIC_STEPS - 1)) state <= C_FIN;
        end
        C_FIN: begin
          heading <= h_fin;
          st.busy <= 1'b0;
          state   <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### sv/magnetometer_heading_filter.sv
// ----------------------------------------------------------------------------
// Magnetometer heading filter
// Offset removal, jump limiting, window average, exponential smoothing,
// field magnitude and compass heading of a three-axis magnetometer stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | beat
//  --------+-----------+------------------+------------------------------
//  in      | input     | in_valid/stall   | in_item_t raw x, y, z
//  out     | output    | out_valid/stall  | out_item_t filtered result
//  cfg     | input     | cfg_valid/ready  | register index + 16-bit data
//
//  The first sample takes only the window fill sweep. Later samples pass
//  through the bit-serial window divider (per axis), the shared shift-add
//  multiplier (smoothing and squares), the one-bit-a-cycle square root and
//  the 22-step CORDIC.
//  Reset is synchronous; no clearing pass is needed.
//  A finished result waits in the output register while the next sample is
//  taken; the engine holds in its last step only if that register is full and stalled.
// ----------------------------------------------------------------------------
`include "magnetometer_heading_filter_macros.svh"

module magnetometer_heading_filter import mhf_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int SW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUMW = 17 + $clog2(WINDOW_DEPTH);
  localparam int DVW  = SUMW + 10;
  localparam int DVR  = $clog2(2 * WINDOW_DEPTH + 1);
  localparam logic [DVR:0] DIVISOR = (DVR+1)'(2 * WINDOW_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_CLAMP, S_DIV, S_SMUL, S_SWAIT, S_SQ, S_SQWAIT,
    S_SQRT, S_SQRND, S_CORD, S_CWAIT, S_HMUL, S_HWAIT, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic signed [15:0] offset_x, offset_y, offset_z, heading_trim;
  logic [14:0]        jump_limit;

  // filter state
  logic signed [15:0]     cur  [3];
  logic signed [23:0]     filt [3];
  logic signed [SUMW-1:0] sums [3];
  logic signed [15:0]     win  [3][WINDOW_DEPTH];
  logic [SW-1:0]          window_slot;
  logic                   primed;
  logic [23:0]            magnitude_hold;
  logic [15:0]            heading_hold;
  logic [3:0]             sector;

  // sequencing and serial datapath registers
  logic [1:0]     ax;
  logic [5:0]     cnt;
  logic [DVW-1:0] divq;
  logic [DVR-1:0] divr;
  logic [47:0]    sq, rad;
  logic [26:0]    srem;
  logic [23:0]    sroot;

  // arithmetic units
  logic                     mul_start;
  logic signed [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0]        mul_b;
  unit_st_t                 mul_st;
  logic signed [MUL_PW-1:0] mul_p;
  logic                     cord_start;
  unit_st_t                 cord_st;
  logic [15:0]              cord_h;

  // combinational datapath
  logic signed [23:0]     f_cur;
  logic signed [15:0]     c_cur, w_cur;
  logic signed [24:0]     fneg;
  logic signed [17:0]     last18, diff18, lim18, lv18;
  logic signed [SUMW-1:0] sum_new;
  logic [SUMW-1:0]        sum_abs;
  logic [DVW-1:0]         div_load;
  logic [DVR:0]           r2;
  logic                   r_ge;
  logic signed [24:0]     avg25, d25, hd25;
  logic signed [16:0]     hd17;
  logic [23:0]            f_abs;
  logic signed [MUL_PW-1:0] psh;
  logic signed [23:0]     f_upd;
  logic [15:0]            h_upd;
  logic [26:0]            s_t, s_trial;
  logic signed [17:0]     tsum, tfix;
  logic [SW-1:0]          slot_inc;
  logic signed [15:0]     cx, cy, cz;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // offset removal with 16-bit wrap
  assign cx = in_data.raw_x - offset_x;
  assign cy = in_data.raw_y - offset_y;
  assign cz = in_data.raw_z - offset_z;

  always_comb begin
    f_cur = filt[ax];
    c_cur = cur[ax];
    w_cur = win[ax][window_slot];

    // jump limit against the filtered value truncated toward zero
    fneg   = -{f_cur[23], f_cur};
    last18 = f_cur[23] ? -$signed({1'b0, fneg[24:8]})
                       : {{2{f_cur[23]}}, f_cur[23:8]};
    diff18 = {{2{c_cur[15]}}, c_cur} - last18;
    lim18  = {3'd0, jump_limit};
    if (diff18 > lim18)       lv18 = last18 + lim18;
    else if (diff18 < -lim18) lv18 = last18 - lim18;
    else                      lv18 = {{2{c_cur[15]}}, c_cur};

    // running window sum and rounded-average dividend
    sum_new  = sums[ax] - {{(SUMW-16){w_cur[15]}}, w_cur}
                        + {{(SUMW-16){lv18[15]}}, lv18[15:0]};
    sum_abs  = sum_new[SUMW-1] ? SUMW'(-sum_new) : SUMW'(sum_new);
    div_load = DVW'({sum_abs, 9'd0}) + DVW'(WINDOW_DEPTH);

    // restoring divider step
    r2   = {divr, divq[DVW-1]};
    r_ge = (r2 >= DIVISOR);

    // smoothing operands
    avg25 = sums[ax][SUMW-1] ? -$signed({1'b0, divq[23:0]}) : $signed({1'b0, divq[23:0]});
    d25   = avg25 - {f_cur[23], f_cur};
    hd17  = $signed({1'b0, cord_h}) - $signed({1'b0, heading_hold});
    hd25  = {{8{hd17[16]}}, hd17};
    f_abs = f_cur[23] ? 24'(-f_cur) : 24'(f_cur);
    psh   = (mul_p + MUL_PW'(32768)) >>> 16;
    f_upd = f_cur + psh[23:0];
    h_upd = heading_hold + psh[15:0];

    // square root step, two radicand bits a cycle
    s_t     = {srem[24:0], rad[47:46]};
    s_trial = {1'b0, sroot, 2'b01};

    // trim with a single wrap
    tsum = $signed({2'b0, heading_hold}) + {{2{heading_trim[15]}}, heading_trim};
    if (tsum > 18'sd46080)  tfix = tsum - 18'sd46080;
    else if (tsum < 18'sd0) tfix = tsum + 18'sd46080;
    else                    tfix = tsum;

    slot_inc = (window_slot == SW'(WINDOW_DEPTH - 1)) ? '0 : window_slot + 1'b1;

    // multiplier operand select
    mul_start  = (state == S_SMUL) || (state == S_SQ) || (state == S_HMUL);
    cord_start = (state == S_CORD);
    case (state)
      S_SQ:    begin mul_a = {1'b0, f_abs}; mul_b = f_abs;     end
      S_HMUL:  begin mul_a = hd25;          mul_b = ALPHA_Q16; end
      default: begin mul_a = d25;           mul_b = ALPHA_Q16; end
    endcase
  end

  mhf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .st      (mul_st),
    .product (mul_p)
  );

  mhf_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .fx      (filt[0]),
    .fy      (filt[1]),
    .st      (cord_st),
    .heading (cord_h)
  );

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      primed         <= 1'b0;
      window_slot    <= '0;
      magnitude_hold <= '0;
      heading_hold   <= '0;
      for (int a = 0; a < 3; a++) filt[a] <= '0;
      offset_x       <= '0;
      offset_y       <= '0;
      offset_z       <= '0;
      jump_limit     <= 15'd50;
      heading_trim   <= '0;
    end else begin
      // the finish step reloads the register itself
      if (out_valid && !out_stall && state != S_FINISH) out_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_OFFSET_X:     offset_x     <= cfg_data;
          CFG_OFFSET_Y:     offset_y     <= cfg_data;
          CFG_OFFSET_Z:     offset_z     <= cfg_data;
          CFG_JUMP_LIMIT:   jump_limit   <= cfg_data[14:0];
          CFG_HEADING_TRIM: heading_trim <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cur[0] <= cx;
            cur[1] <= cy;
            cur[2] <= cz;
            sector <= sector_of(heading_hold);
            ax     <= '0;
            cnt    <= '0;
            state  <= primed ? S_CLAMP : S_FILL;
          end
        end
        // first sample: sweep the window, building the sums
        S_FILL: begin
          for (int a = 0; a < 3; a++) begin
            win[a][cnt[SW-1:0]] <= cur[a];
            sums[a] <= (cnt == '0) ? {{(SUMW-16){cur[a][15]}}, cur[a]}
                                   : sums[a] + {{(SUMW-16){cur[a][15]}}, cur[a]};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(WINDOW_DEPTH - 1)) begin
            for (int a = 0; a < 3; a++) filt[a] <= {cur[a], 8'd0};
            primed <= 1'b1;
            state  <= S_FINISH;
          end
        end
        S_CLAMP: begin
          win[ax][window_slot] <= lv18[15:0];
          sums[ax] <= sum_new;
          divq     <= div_load;
          divr     <= '0;
          cnt      <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          divr <= r_ge ? DVR'(r2 - DIVISOR) : r2[DVR-1:0];
          divq <= {divq[DVW-2:0], r_ge};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(DVW - 1)) state <= S_SMUL;
        end
        S_SMUL: state <= S_SWAIT;
        S_SWAIT: begin
          if (mul_st.done) begin
            filt[ax] <= f_upd;
            if (ax == 2'd2) begin
              ax    <= '0;
              sq    <= '0;
              state <= S_SQ;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_CLAMP;
            end
          end
        end
        S_SQ: state <= S_SQWAIT;
        S_SQWAIT: begin
          if (mul_st.done) begin
            sq <= sq + mul_p[47:0];
            if (ax == 2'd2) begin
              rad   <= sq + mul_p[47:0];
              srem  <= '0;
              sroot <= '0;
              cnt   <= '0;
              state <= S_SQRT;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_SQ;
            end
          end
        end
        S_SQRT: begin
          if (s_t >= s_trial) begin
            srem  <= s_t - s_trial;
            sroot <= {sroot[22:0], 1'b1};
          end else begin
            srem  <= s_t;
            sroot <= {sroot[22:0], 1'b0};
          end
          rad <= {rad[45:0], 2'b00};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd23) state <= S_SQRND;
        end
        S_SQRND: begin
          magnitude_hold <= (srem > {3'd0, sroot}) ? sroot + 24'd1 : sroot;
          state <= S_CORD;
        end
        S_CORD: state <= S_CWAIT;
        S_CWAIT: if (cord_st.done) state <= S_HMUL;
        S_HMUL: state <= S_HWAIT;
        S_HWAIT: begin
          if (mul_st.done) begin
            heading_hold <= h_upd;
            window_slot  <= slot_inc;
            state        <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.smooth_x        <= filt[0];
            out_data.smooth_y        <= filt[1];
            out_data.smooth_z        <= filt[2];
            out_data.field_strength  <= magnitude_hold;
            out_data.heading         <= heading_hold;
            out_data.trimmed_heading <= tfix[15:0];
            out_data.compass_sector  <= sector;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `MHF_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)
  `MHF_ASSERT_IMP(a_mul_free, clk, rst, mul_start, !mul_st.busy)
  `MHF_ASSERT_IMP(a_slot_range, clk, rst, 1'b1, window_slot <= SW'(WINDOW_DEPTH - 1))
  `MHF_ASSERT_NXT(a_finish_load, clk, rst, state == S_FINISH && (!out_valid || !out_stall), out_valid && state == S_IDLE)

endmodule

### tb/sv/magnetometer_heading_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer heading filter testbench
// Streams raw three-axis samples through the filter under several register
// settings. Sender gaps and receiver stalls come in random bursts. Every
// result is checked field by field against an in-bench model of the filter.
// ----------------------------------------------------------------------------
module magnetometer_heading_filter_tb;
  import mhf_pkg::*;

  localparam int DEPTH       = WINDOW_DEPTH_DEF;
  localparam int DRAIN_WAIT  = 400;
  localparam int CYCLE_LIMIT = 3000000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [15:0]       cfg_data;

  magnetometer_heading_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Filter model state
  longint m_off_x, m_off_y, m_off_z, m_jump, m_trim;
  longint m_xw [DEPTH];
  longint m_yw [DEPTH];
  longint m_zw [DEPTH];
  int     m_slot;
  bit     m_primed;
  longint m_fx, m_fy, m_fz, m_mag, m_hdg;

  in_item_t  sample_queue [$];
  out_item_t expected_results [$];
  int        errors;
  int        samples_taken;
  int        results_seen;
  bit        quiet;
  longint    cycles;

  function automatic longint trunc_q8(longint f);
    return (f >= 0) ? (f >>> 8) : -((-f) >>> 8);
  endfunction

  function automatic longint ema(longint f, longint target);
    return f + ((64'sd6554 * (target - f) + 64'sd32768) >>> 16);
  endfunction

  function automatic longint limit_jump(longint s, longint f);
    longint last;
    last = trunc_q8(f);
    if (s - last > m_jump) return last + m_jump;
    if (s - last < -m_jump) return last - m_jump;
    return s;
  endfunction

  function automatic longint window_avg(ref longint w [DEPTH], input longint v,
                                        input longint f);
    longint sum, n, avg;
    sum = 0;
    w[m_slot] = v;
    for (int i = 0; i < DEPTH; i++) sum += w[i];
    n = sum * 256;
    if (n >= 0) avg = (2 * n + DEPTH) / (2 * DEPTH);
    else avg = -((-2 * n + DEPTH) / (2 * DEPTH));
    return ema(f, avg);
  endfunction

  function automatic longint sqrt_round(longint unsigned v);
    longint unsigned rem, res, b;
    rem = v; res = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    if (v - res * res > res) res++;
    return longint'(res);
  endfunction

  // CORDIC heading in 1/128 degree, offset by 90 degrees
  function automatic longint compass_angle(longint fx, longint fy);
    longint x, y, z, xs, ys, a, h;
    x = fx * 256; y = fy * 256; z = 0;
    if (fx != 0 || fy != 0) begin
      if (x < 0) begin
        x = -x; y = -y; z = 180 * DEG_UNIT;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z += longint'(ATAN_TABLE[i]);
        end else begin
          x = x - ys; y = y + xs; z -= longint'(ATAN_TABLE[i]);
        end
      end
    end
    a = z + 90 * DEG_UNIT;
    if (a < 0) a += 360 * DEG_UNIT;
    if (a >= 360 * DEG_UNIT) a -= 360 * DEG_UNIT;
    h = (a + 128) >>> 8;
    if (h >= FULL_TURN) h -= FULL_TURN;
    return h;
  endfunction

  // Advance the model by one sample and return the expected beat
  function automatic out_item_t filter_step(in_item_t s);
    out_item_t r;
    logic signed [15:0] cx, cy, cz;
    longint lx, ly, lz, tr;
    logic [3:0] sec;
    cx = s.raw_x - 16'(m_off_x);
    cy = s.raw_y - 16'(m_off_y);
    cz = s.raw_z - 16'(m_off_z);
    sec = SECTOR_CODES[((m_hdg + HALF_SECTOR) / SECTOR_SPAN) & 7];
    if (m_slot >= DEPTH) m_slot = 0;
    if (!m_primed) begin
      for (int i = 0; i < DEPTH; i++) begin
        m_xw[i] = cx; m_yw[i] = cy; m_zw[i] = cz;
      end
      m_fx = longint'(cx) * 256;
      m_fy = longint'(cy) * 256;
      m_fz = longint'(cz) * 256;
      m_primed = 1'b1;
    end else begin
      lx = limit_jump(cx, m_fx);
      ly = limit_jump(cy, m_fy);
      lz = limit_jump(cz, m_fz);
      m_fx = window_avg(m_xw, lx, m_fx);
      m_fy = window_avg(m_yw, ly, m_fy);
      m_fz = window_avg(m_zw, lz, m_fz);
      m_slot++;
      if (m_slot >= DEPTH) m_slot = 0;
      m_mag = sqrt_round(m_fx * m_fx + m_fy * m_fy + m_fz * m_fz);
      m_hdg = ema(m_hdg, compass_angle(m_fx, m_fy));
    end
    tr = m_hdg + m_trim;
    if (tr > FULL_TURN) tr -= FULL_TURN;
    else if (tr < 0) tr += FULL_TURN;
    r.smooth_x        = 24'(m_fx);
    r.smooth_y        = 24'(m_fy);
    r.smooth_z        = 24'(m_fz);
    r.field_strength  = 24'(m_mag);
    r.heading         = 16'(m_hdg);
    r.trimmed_heading = 16'(tr);
    r.compass_sector  = sec;
    return r;
  endfunction

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Input driver: takes samples from the queue, random gap bursts
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(filter_step(in_data));
        samples_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_data  <= sample_queue.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each beat, random stall bursts
  int stall_left;
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result beat %0h", $realtime, out_data);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("smooth_x", e.smooth_x, out_data.smooth_x);
          check_field("smooth_y", e.smooth_y, out_data.smooth_y);
          check_field("smooth_z", e.smooth_z, out_data.smooth_z);
          check_field("field_strength", e.field_strength, out_data.field_strength);
          check_field("heading", 24'(e.heading), 24'(out_data.heading));
          check_field("trimmed_heading", 24'(e.trimmed_heading),
                      24'(out_data.trimmed_heading));
          check_field("compass_sector", 24'(e.compass_sector),
                      24'(out_data.compass_sector));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // One register write; the caller drops cfg_valid after the last one
  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OFFSET_X:     m_off_x = longint'($signed(v));
      CFG_OFFSET_Y:     m_off_y = longint'($signed(v));
      CFG_OFFSET_Z:     m_off_z = longint'($signed(v));
      CFG_JUMP_LIMIT:   m_jump  = longint'(v[14:0]);
      CFG_HEADING_TRIM: m_trim  = longint'($signed(v));
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                         logic [15:0] jl, logic [15:0] tr);
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_OFFSET_Z, oz);
    write_reg(CFG_JUMP_LIMIT, jl);
    write_reg(CFG_HEADING_TRIM, tr);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(int x, int y, int z);
    in_item_t s;
    s.raw_x = 16'(x); s.raw_y = 16'(y); s.raw_z = 16'(z);
    sample_queue.push_back(s);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Mostly a drifting field with small noise, some jumps and pure noise
  task automatic random_phase(int count);
    int bx, by, bz, r;
    bx = $urandom_range(0, 4000) - 2000;
    by = $urandom_range(0, 4000) - 2000;
    bz = $urandom_range(0, 4000) - 2000;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        push_sample($urandom, $urandom, $urandom);
      end else if (r == 1) begin
        bx = $urandom_range(0, 60000) - 30000;
        by = $urandom_range(0, 60000) - 30000;
        bz = $urandom_range(0, 60000) - 30000;
        push_sample(bx, by, bz);
      end else begin
        bx += $urandom_range(0, 40) - 20;
        by += $urandom_range(0, 40) - 20;
        bz += $urandom_range(0, 40) - 20;
        push_sample(bx + $urandom_range(0, 120) - 60, by + $urandom_range(0, 120) - 60,
                    bz + $urandom_range(0, 120) - 60);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    errors = 0; samples_taken = 0; results_seen = 0; quiet = 1'b0; cycles = 0;
    m_off_x = 0; m_off_y = 0; m_off_z = 0; m_jump = 50; m_trim = 0;
    for (int i = 0; i < DEPTH; i++) begin
      m_xw[i] = 0; m_yw[i] = 0; m_zw[i] = 0;
    end
    m_slot = 0; m_primed = 1'b0;
    m_fx = 0; m_fy = 0; m_fz = 0; m_mag = 0; m_hdg = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: seeding at zero, zero field, extremes, jumps in both directions
    for (int i = 0; i < 4; i++) push_sample(0, 0, 0);
    push_sample(32767, 32767, 32767);
    push_sample(-32768, -32768, -32768);
    push_sample(32767, -32768, 0);
    push_sample(-32768, 32767, -1);
    push_sample(-1, -1, -1);
    push_sample(100, 0, 0);
    push_sample(-100, 20, 0);
    push_sample(0, -300, 5);
    push_sample(40, 40, 40);
    drain();

    // Extreme offsets force wrap, jump limit of zero, trim at its negative end
    set_all(16'h8000, 16'h7fff, 16'h8000, 16'd0, -16'sd23040);
    push_sample(32767, -32768, 32767);
    push_sample(0, 0, 0);
    push_sample(-32768, 32767, -32768);
    push_sample(1, -1, 1);
    random_phase(250);
    drain();

    set_all(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'sd23040);
    push_sample(-32768, 32767, -32768);
    push_sample(32767, -32768, 32767);
    random_phase(300);
    drain();

    set_all(16'(-120), 16'(75), 16'(300), 16'd50, 16'sd0);
    random_phase(300);
    drain();

    set_all($urandom, $urandom, $urandom, 16'($urandom_range(0, 400)),
            16'($urandom_range(0, 46080) - 23040));
    random_phase(300);
    drain();

    // Last part: no gaps and no stalls
    set_all(16'd0, 16'd0, 16'd0, 16'd1, 16'sd11520);
    quiet = 1'b1;
    random_phase(370);
    drain();

    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("covered %0d samples and %0d results over six register settings",
             samples_taken, results_seen);
    $display("including extreme offsets, jump limits and heading trims, %0d errors",
             errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
